// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the CRC-8 frame parser.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
		else $error("assertion failed");
// When trig holds, prop must hold in the cycle after.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, trig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (trig) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, prop)
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, trig, prop)
`endif

`endif

// ===== src/crc8sfp_pkg.sv =====
// Types, constants and the CRC-8 byte update for the serial frame parser.
// No dependencies.
package crc8sfp_pkg;

	localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
	localparam logic [7:0] CRC_POLY      = 8'h31;
	localparam logic [7:0] CRC_INIT      = 8'hFF;

	// Frame phase, one-hot.
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_ID      = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_PARSING = 2'd1,
		ST_GOOD    = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

	// MSB-first CRC-8 over one byte, no reflection.
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== src/crc8_serial_frame_parser_unit.sv =====
// Framed serial packet deframer with on-the-fly CRC-8 (poly 0x31, init 0xFF).
// Uses crc8sfp_pkg and assert_macros.svh.

// One received byte goes in per word and exactly one status word comes out.
// The unit hunts for the preamble 0xFE, then reads a header byte (sequence
// in bits 7..4, payload length in bits 3..0), a message id, the payload and
// a CRC-8 check byte covering header through payload. Each output word
// echoes the byte with its index after the preamble, the header fields and
// a status: idle (hunting, preamble included; index and header fields read
// zero), parsing, good frame or bad checksum frame. A good frame also
// flags seq_error when its sequence differs from the expected one; the
// expected sequence then becomes received sequence plus one, mod 16.
// Throughput is one byte per clock while the output is not stalled: the
// byte-wide CRC update and the frame state advance are combinational logic
// between the input register and the output register. An accepted byte is
// held in the input register, then its result in the output register,
// where out_valid rises. The input register can still take a byte while a
// finished result waits on out_ready, so in_ready drops only when both
// registers are full and the output is stalled.
module crc8_serial_frame_parser_unit
	import crc8sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] byte_value,
	output logic [4:0] byte_index,
	output logic [3:0] frame_seq,
	output logic [3:0] payload_len,
	output logic       seq_error
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Output register
	logic       valid_s2;
	status_t    status_s2;
	logic [7:0] byte_s2;
	logic [4:0] index_s2;
	logic [3:0] seq_s2;
	logic [3:0] len_s2;
	logic       serr_s2;

	// Frame state
	phase_t     phase_q;
	logic [3:0] left_q;
	logic [4:0] pos_q;
	logic [7:0] crc_q;
	logic [3:0] exp_seq_q;
	logic [3:0] hseq_q;
	logic [3:0] hlen_q;

	// Next-state and result from the word in the input register
	phase_t     phase_d;
	logic [3:0] left_d;
	logic [4:0] pos_d;
	logic [7:0] crc_d;
	logic [3:0] exp_seq_d;
	logic [3:0] hseq_d;
	logic [3:0] hlen_d;
	status_t    status_d;
	logic [4:0] index_d;
	logic       serr_d;
	logic [3:0] left_dec;

	logic adv_s2;  // output register can load
	logic adv_s1;  // input register word moves on

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign left_dec = left_q - 4'd1;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		pos_d     = pos_q;
		crc_d     = crc_q;
		exp_seq_d = exp_seq_q;
		hseq_d    = hseq_q;
		hlen_d    = hlen_q;
		status_d  = ST_IDLE;
		index_d   = 5'd0;
		serr_d    = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				hseq_d   = byte_s1[7:4];
				hlen_d   = byte_s1[3:0];
				left_d   = byte_s1[3:0];
				crc_d    = crc8_next(CRC_INIT, byte_s1);
				pos_d    = 5'd1;
				phase_d  = PH_ID;
				status_d = ST_PARSING;
			end
			PH_ID: begin
				crc_d    = crc8_next(crc_q, byte_s1);
				index_d  = pos_q;
				pos_d    = pos_q + 5'd1;
				phase_d  = (left_q != 4'd0) ? PH_PAYLOAD : PH_CHECK;
				status_d = ST_PARSING;
			end
			PH_PAYLOAD: begin
				crc_d    = crc8_next(crc_q, byte_s1);
				index_d  = pos_q;
				pos_d    = pos_q + 5'd1;
				left_d   = left_dec;
				phase_d  = (left_dec == 4'd0) ? PH_CHECK : PH_PAYLOAD;
				status_d = ST_PARSING;
			end
			PH_CHECK: begin
				index_d = pos_q;
				if (byte_s1 == crc_q) begin
					status_d  = ST_GOOD;
					serr_d    = (hseq_q != exp_seq_q);
					exp_seq_d = hseq_q + 4'd1;
				end else begin
					status_d = ST_BAD;
				end
				phase_d = PH_HUNT;
				pos_d   = 5'd0;
				left_d  = 4'd0;
				crc_d   = CRC_INIT;
			end
			default: begin
				// hunting; stray codes fall back here too
				phase_d = (byte_s1 == PREAMBLE_BYTE) ? PH_HEADER : PH_HUNT;
				pos_d   = 5'd0;
				left_d  = 4'd0;
				crc_d   = CRC_INIT;
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Frame state advances as the word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			left_q    <= 4'd0;
			pos_q     <= 5'd0;
			crc_q     <= CRC_INIT;
			exp_seq_q <= 4'd0;
			hseq_q    <= 4'd0;
			hlen_q    <= 4'd0;
		end else if (adv_s1) begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			exp_seq_q <= exp_seq_d;
			hseq_q    <= hseq_d;
			hlen_q    <= hlen_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_d;
			byte_s2   <= byte_s1;
			index_s2  <= index_d;
			serr_s2   <= serr_d;
			// header fields only shown outside the hunt
			seq_s2    <= (status_d != ST_IDLE) ? hseq_d : 4'd0;
			len_s2    <= (status_d != ST_IDLE) ? hlen_d : 4'd0;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign byte_value  = byte_s2;
	assign byte_index  = index_s2;
	assign frame_seq   = seq_s2;
	assign payload_len = len_s2;
	assign seq_error   = serr_s2;

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_serr_good_only, clk, arst_n, !(out_valid && seq_error && (status_s2 != ST_GOOD)))
	`ASSERT_ALWAYS(a_idle_fields_zero, clk, arst_n, !(out_valid && (status_s2 == ST_IDLE)) || ((byte_index == 5'd0) && (frame_seq == 4'd0) && (payload_len == 4'd0)))
	`ASSERT_NEXT(a_exp_seq_update, clk, arst_n, adv_s1 && (status_d == ST_GOOD), exp_seq_q == $past(hseq_q + 4'd1))
	`ASSERT_ALWAYS(a_stall_only_full, clk, arst_n, in_ready || (valid_s1 && valid_s2 && !out_ready))

endmodule
